@@ rtl/rrts_pkg.sv @@
// Shared types and codes for the round robin task scheduler.
package rrts_pkg;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SET  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  localparam logic [2:0] ST_CREATED    = 3'd0;
  localparam logic [2:0] ST_READY      = 3'd1;
  localparam logic [2:0] ST_RUNNING    = 3'd2;
  localparam logic [2:0] ST_BLOCKED    = 3'd3;
  localparam logic [2:0] ST_TERMINATED = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOTFND  = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_NORUN   = 2'd3;

  localparam logic [1:0] REG_SHORT  = 2'd0;
  localparam logic [1:0] REG_NORMAL = 2'd1;
  localparam logic [1:0] REG_KERNEL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_SEL_INIT,
    S_WALK,
    S_UNLINK,
    S_FINISH,
    S_ADD,
    S_SET_SCAN,
    S_SET_APPLY,
    S_OUT
  } fsm_t;

endpackage

@@ rtl/round_robin_task_scheduler_core.sv @@
// Top level of the round robin task scheduler: slot table and sequencer.
// A no-op and a tick without reselection go to the output state without a walk; a
// reselecting tick walks toward older slots and unlinks terminated non-kernel ones on the
// way, and add and set by id scan the slot table. One request at a time; in_stall is high
// from acceptance until the result leaves the output register, after which the next
// request can be taken. Sync reset leaves only slot zero linked.
module round_robin_task_scheduler_core #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic        target_current,
  input  logic [7:0]  process_id,
  input  logic [2:0]  new_state,
  input  logic [8:0]  slice_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  run_id,
  output logic        switched,
  output logic [1:0]  status,
  output logic [4:0]  reclaimed,
  output logic [31:0] tick_count
);
  import rrts_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int PW = SW + 1;
  localparam int CW = $clog2(SLOTS + 2);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // Configuration
  logic [7:0] short_slice, normal_slice, kernel_id;

  // Slot table
  logic                     slot_valid [SLOTS];
  logic [7:0]               slot_id    [SLOTS];
  logic [2:0]               slot_state [SLOTS];
  logic signed [15:0]       slot_slice [SLOTS];
  logic [PW-1:0]            slot_older [SLOTS];
  logic [PW-1:0]            newest_slot;
  logic [SW-1:0]            current_slot;
  logic [31:0]              ticks_seen;

  // Latched request and working registers
  fsm_t                     state, state_next;
  logic                     req_tgt;
  logic [7:0]               req_pid;
  logic [2:0]               req_nst;
  logic signed [8:0]        req_sv;
  logic [PW-1:0]            p;
  logic [PW-1:0]            victim;
  logic [CW-1:0]            steps;
  logic [CW-1:0]            scan;
  logic [PW-1:0]            found;
  logic [4:0]               gone;
  logic                     moved;
  logic [1:0]               stat;

  // Handshake
  assign in_stall = (state != S_IDLE);
  wire accept = in_valid && !in_stall;
  wire out_take = out_valid && !out_stall;

  // Index helpers on the working pointers
  logic [SW-1:0] pi, si, vi, fi;
  assign pi = p[SW-1:0];
  assign si = scan[SW-1:0];
  assign vi = victim[SW-1:0];
  assign fi = found[SW-1:0];

  logic [PW-1:0] nxt;
  always_comb begin
    if (p >= NIL) nxt = newest_slot;
    else nxt = slot_older[pi];
    if (nxt >= NIL) nxt = newest_slot;
  end
  wire [SW-1:0] ni = nxt[SW-1:0];
  wire scan_end = (scan == CW'(SLOTS));

  // Current slice after one tick, saturating at the bottom
  logic signed [15:0] cur_dec;
  assign cur_dec = (slot_slice[current_slot] != -16'sd32768) ?
                   slot_slice[current_slot] - 16'sd1 : slot_slice[current_slot];

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_t'(mode))
            MODE_TICK: state_next = S_TICK;
            MODE_ADD:  state_next = S_ADD;
            MODE_SET:  state_next = target_current ? S_SET_APPLY : S_SET_SCAN;
            default:   state_next = S_OUT;
          endcase
        end
      end
      S_TICK: begin
        if (cur_dec <= 16'sd0 ||
            slot_state[current_slot] != ST_RUNNING) state_next = S_SEL_INIT;
        else state_next = S_OUT;
      end
      S_SEL_INIT: state_next = S_WALK;
      S_WALK: begin
        if (newest_slot >= NIL || nxt >= NIL || steps > CW'(SLOTS))
          state_next = S_OUT;
        else if (slot_state[ni] == ST_TERMINATED && slot_id[ni] != kernel_id)
          state_next = S_UNLINK;
        else if (slot_state[ni] == ST_READY || slot_state[ni] == ST_CREATED)
          state_next = S_FINISH;
      end
      S_UNLINK: begin
        if (newest_slot == victim || scan_end ||
            (slot_valid[si] && slot_older[si] == victim)) state_next = S_WALK;
      end
      S_FINISH: state_next = S_OUT;
      S_ADD: begin
        if (scan_end || !slot_valid[si]) state_next = S_OUT;
      end
      S_SET_SCAN: begin
        if (found >= NIL || scan_end || slot_id[fi] == req_pid)
          state_next = S_SET_APPLY;
      end
      S_SET_APPLY: state_next = S_OUT;
      S_OUT: if (out_take || !out_valid) state_next = out_valid ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      short_slice  <= 8'd1;
      normal_slice <= 8'd4;
      kernel_id    <= 8'd0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_valid[s] <= (s == 0);
        slot_id[s]    <= 8'd0;
        slot_state[s] <= (s == 0) ? ST_READY : ST_CREATED;
        slot_slice[s] <= (s == 0) ? 16'sd1 : 16'sd0;
        slot_older[s] <= NIL;
      end
      newest_slot  <= '0;
      current_slot <= '0;
      ticks_seen   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SHORT:  short_slice  <= cfg_data;
          REG_NORMAL: normal_slice <= cfg_data;
          REG_KERNEL: kernel_id    <= cfg_data;
          default: ;
        endcase
      end
      if (out_take) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_tgt  <= target_current;
            req_pid  <= process_id;
            req_nst  <= new_state;
            req_sv   <= slice_value;
            gone     <= '0;
            moved    <= 1'b0;
            stat     <= STAT_OK;
            scan     <= '0;
            found    <= newest_slot;
          end
        end
        S_TICK: begin
          ticks_seen <= ticks_seen + 32'd1;
          slot_slice[current_slot] <= cur_dec;
        end
        S_SEL_INIT: begin
          p <= slot_valid[current_slot] ? PW'(current_slot) : NIL;
          steps <= '0;
          if (slot_valid[current_slot] && slot_state[current_slot] == ST_RUNNING)
            slot_state[current_slot] <= ST_READY;
        end
        S_WALK: begin
          if (newest_slot >= NIL || nxt >= NIL || steps > CW'(SLOTS)) begin
            stat <= STAT_NORUN;
          end else begin
            p <= nxt;
            steps <= steps + CW'(1);
            victim <= nxt;
            scan <= '0;
          end
        end
        S_UNLINK: begin
          if (newest_slot == victim || scan_end ||
              (slot_valid[si] && slot_older[si] == victim)) begin
            if (newest_slot == victim) newest_slot <= slot_older[vi];
            else if (!scan_end) slot_older[si] <= slot_older[vi];
            slot_valid[vi] <= 1'b0;
            slot_id[vi]    <= 8'd0;
            slot_state[vi] <= ST_CREATED;
            slot_slice[vi] <= 16'sd0;
            slot_older[vi] <= NIL;
            gone  <= gone + 5'd1;
            p     <= (newest_slot == victim) ? slot_older[vi] : newest_slot;
            steps <= '0;
          end else begin
            scan <= scan + CW'(1);
          end
        end
        S_FINISH: begin
          if (pi != current_slot) begin
            if (slot_valid[current_slot] && slot_state[current_slot] != ST_BLOCKED)
              slot_state[current_slot] <= ST_READY;
            slot_slice[pi] <= (slot_id[pi] == kernel_id) ? {8'd0, short_slice}
                                                          : {8'd0, normal_slice};
            moved <= 1'b1;
          end else if (slot_slice[pi] < 16'sd0) begin
            slot_slice[pi] <= {8'd0, short_slice};
          end
          current_slot <= pi;
        end
        S_ADD: begin
          if (scan_end) begin
            stat <= STAT_FULL;
          end else if (!slot_valid[si]) begin
            slot_valid[si] <= 1'b1;
            slot_id[si]    <= req_pid;
            slot_state[si] <= req_nst;
            slot_slice[si] <= req_sv[8] ? {8'd0, short_slice} : 16'(req_sv);
            slot_older[si] <= newest_slot;
            newest_slot    <= PW'(si);
          end else begin
            scan <= scan + CW'(1);
          end
        end
        S_SET_SCAN: begin
          if (found >= NIL || scan_end) found <= NIL;
          else if (slot_id[fi] != req_pid) begin
            found <= slot_older[fi];
            scan  <= scan + CW'(1);
          end
        end
        S_SET_APPLY: begin
          logic [PW-1:0] t;
          t = req_tgt ? (slot_valid[current_slot] ? PW'(current_slot) : NIL) : found;
          if (t >= NIL) stat <= STAT_NOTFND;
          else begin
            slot_state[t[SW-1:0]] <= req_nst;
            if (!req_sv[8]) slot_slice[t[SW-1:0]] <= 16'(req_sv);
          end
        end
        S_OUT: begin
          if (!out_valid && state_next == S_OUT) begin
            out_valid  <= 1'b1;
            run_id     <= slot_id[current_slot];
            switched   <= moved;
            status     <= stat;
            reclaimed  <= gone;
            tick_count <= ticks_seen;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    int'(current_slot) < SLOTS) else $error("current slot out of range");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the round robin task scheduler core.
`timescale 1ns / 1ps

typedef struct {
  logic [7:0]  run_id;
  logic        switched;
  logic [1:0]  status;
  logic [4:0]  reclaimed;
  logic [31:0] tick_count;
} sched_result_t;

module tb_top;
  import rrts_pkg::*;

  localparam int NSLOT = 16;
  localparam int NIL   = NSLOT;

  // Predicts the task table and holds expected results in request order
  class sched_scoreboard;
    bit [7:0]      short_r, normal_r, kernel_r;
    bit            vld[NSLOT];
    bit [7:0]      tid[NSLOT];
    bit [2:0]      tst[NSLOT];
    int            tslice[NSLOT];
    int            older[NSLOT];
    int            newest, cur_slot;
    bit [31:0]     ticks;
    sched_result_t pending[$];
    int            errors;

    function new();
      short_r  = 1;
      normal_r = 4;
      kernel_r = 0;
      for (int s = 0; s < NSLOT; s++) begin
        vld[s] = 0; tid[s] = 0; tst[s] = 0; tslice[s] = 0; older[s] = NIL;
      end
      vld[0]    = 1;
      tst[0]    = ST_READY;
      tslice[0] = short_r;
      newest    = 0;
      cur_slot  = 0;
      ticks     = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      if (idx == REG_SHORT) short_r = val;
      else if (idx == REG_NORMAL) normal_r = val;
      else if (idx == REG_KERNEL) kernel_r = val;
    endfunction

    function int step_older(int p);
      int q;
      q = (p >= NIL) ? newest : older[p];
      if (q >= NIL) q = newest;
      return q;
    endfunction

    function void drop_slot(int v);
      if (newest == v) begin
        newest = older[v];
      end else begin
        for (int s = 0; s < NSLOT; s++) begin
          if (vld[s] && older[s] == v) begin
            older[s] = older[v];
            break;
          end
        end
      end
      vld[v] = 0; tid[v] = 0; tst[v] = 0; tslice[v] = 0; older[v] = NIL;
    endfunction

    // Walk from the current task toward older entries; unlink terminated non-kernel ones
    function bit pick_task(inout int gone, inout bit moved);
      int cur, p, steps, pick;
      bit [2:0] s;
      cur   = cur_slot;
      p     = vld[cur] ? cur : NIL;
      steps = 0;
      pick  = NIL;
      moved = 0;
      if (vld[cur] && tst[cur] == ST_RUNNING) tst[cur] = ST_READY;
      while (steps <= NSLOT) begin
        if (newest >= NIL) break;
        p = step_older(p);
        if (p >= NIL) break;
        steps++;
        s = tst[p];
        if (s == ST_TERMINATED) begin
          if (tid[p] != kernel_r) begin
            drop_slot(p);
            gone++;
            p     = newest;
            steps = 0;
          end
          continue;
        end
        if (s == ST_READY || s == ST_CREATED) begin
          pick = p;
          break;
        end
      end
      if (pick >= NIL) return 0;
      if (pick != cur) begin
        if (vld[cur] && tst[cur] != ST_BLOCKED) tst[cur] = ST_READY;
        tslice[pick] = (tid[pick] == kernel_r) ? short_r : normal_r;
        moved = 1;
      end
      if (tslice[pick] < 0) tslice[pick] = short_r;
      cur_slot = pick;
      return 1;
    endfunction

    // Apply one accepted request and queue the result it should give
    function void note_request(logic [1:0] m, logic tc, logic [7:0] pid,
                               logic [2:0] nst, logic [8:0] sv9);
      int            sv, gone, f, t, p, n, cur;
      bit            moved;
      logic [1:0]    stat;
      sched_result_t r;
      sv    = $signed(sv9);
      gone  = 0;
      moved = 0;
      stat  = STAT_OK;
      case (mode_t'(m))
        MODE_TICK: begin
          cur = cur_slot;
          ticks++;
          if (tslice[cur] > -32768) tslice[cur]--;
          if (tslice[cur] <= 0 || tst[cur] != ST_RUNNING) begin
            if (!pick_task(gone, moved)) stat = STAT_NORUN;
          end
        end
        MODE_ADD: begin
          f = NIL;
          for (int s = 0; s < NSLOT; s++) begin
            if (!vld[s]) begin
              f = s;
              break;
            end
          end
          if (f >= NIL) begin
            stat = STAT_FULL;
          end else begin
            vld[f]    = 1;
            tid[f]    = pid;
            tst[f]    = nst;
            tslice[f] = (sv < 0) ? short_r : sv;
            older[f]  = newest;
            newest    = f;
          end
        end
        MODE_SET: begin
          t = NIL;
          if (tc) begin
            if (vld[cur_slot]) t = cur_slot;
          end else begin
            p = newest;
            n = 0;
            while (p < NIL && n < NSLOT) begin
              if (tid[p] == pid) begin
                t = p;
                break;
              end
              p = older[p];
              n++;
            end
          end
          if (t >= NIL) begin
            stat = STAT_NOTFND;
          end else begin
            tst[t] = nst;
            if (sv >= 0) tslice[t] = sv;
          end
        end
        default: ;
      endcase
      r.run_id     = tid[cur_slot];
      r.switched   = moved;
      r.status     = stat;
      r.reclaimed  = gone[4:0];
      r.tick_count = ticks;
      pending.push_back(r);
    endfunction

    function void check_result(sched_result_t act);
      sched_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: result with no request outstanding, run_id %0d", $time, act.run_id);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (act.run_id !== exp_r.run_id) begin
        $display("%0t: run_id exp %0d got %0d", $time, exp_r.run_id, act.run_id);
        errors++;
      end
      if (act.switched !== exp_r.switched) begin
        $display("%0t: switched exp %0d got %0d", $time, exp_r.switched, act.switched);
        errors++;
      end
      if (act.status !== exp_r.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp_r.status, act.status);
        errors++;
      end
      if (act.reclaimed !== exp_r.reclaimed) begin
        $display("%0t: reclaimed exp %0d got %0d", $time, exp_r.reclaimed, act.reclaimed);
        errors++;
      end
      if (act.tick_count !== exp_r.tick_count) begin
        $display("%0t: tick_count exp %0d got %0d", $time, exp_r.tick_count,
                 act.tick_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  mode = MODE_NOP;
  logic        target_current = 0;
  logic [7:0]  process_id = '0;
  logic [2:0]  new_state = '0;
  logic [8:0]  slice_value = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  run_id;
  logic        switched;
  logic [1:0]  status;
  logic [4:0]  reclaimed;
  logic [31:0] tick_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  sched_scoreboard sb = new();

  round_robin_task_scheduler_core #(.SLOTS(NSLOT)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .target_current(target_current), .process_id(process_id),
    .new_state(new_state), .slice_value(slice_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .run_id(run_id), .switched(switched), .status(status),
    .reclaimed(reclaimed), .tick_count(tick_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    sched_result_t act;
    if (!rst && out_valid && !out_stall) begin
      act.run_id     = run_id;
      act.switched   = switched;
      act.status     = status;
      act.reclaimed  = reclaimed;
      act.tick_count = tick_count;
      sb.check_result(act);
    end
  end

  // Register write, only while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Present one request and hold it until accepted
  task automatic send_req(input logic [1:0] m, input logic tc, input logic [7:0] pid,
                          input logic [2:0] nst, input logic [8:0] sv);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    mode           = m;
    target_current = tc;
    process_id     = pid;
    new_state      = nst;
    slice_value    = sv;
    in_valid       = 1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_request(m, tc, pid, nst, sv);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid = 0;
  endtask

  // Mostly plausible task traffic with random content
  task automatic send_random();
    int          r;
    logic [1:0]  m;
    logic [7:0]  pid;
    logic [2:0]  nst;
    logic [8:0]  sv;
    r   = $urandom_range(99);
    m   = (r < 42) ? MODE_TICK : (r < 62) ? MODE_ADD : (r < 95) ? MODE_SET : MODE_NOP;
    pid = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    r   = $urandom_range(99);
    nst = (r < 8) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(ST_TERMINATED));
    r   = $urandom_range(99);
    sv  = (r < 20) ? 9'h1FF : (r < 30) ? 9'($urandom) : (r < 90) ? 9'($urandom_range(6))
        : 9'($urandom_range(255));
    send_req(m, $urandom_range(3) == 0, pid, nst, sv);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_reg(REG_SHORT, 8'd2);
    write_reg(REG_NORMAL, 8'd3);
    write_reg(REG_KERNEL, 8'd0);

    // Directed opening
    send_req(MODE_TICK, 0, 8'd0, ST_READY, 9'd0);
    send_req(MODE_ADD, 0, 8'd1, ST_READY, 9'd0);
    send_req(MODE_ADD, 0, 8'd2, ST_CREATED, 9'h1FF);
    send_req(MODE_ADD, 0, 8'd255, 3'd7, 9'd255);
    send_req(MODE_ADD, 0, 8'd1, ST_BLOCKED, 9'h100);
    send_req(MODE_SET, 0, 8'd2, ST_BLOCKED, 9'h1FF);
    send_req(MODE_SET, 1, 8'd77, ST_RUNNING, 9'd5);
    send_req(MODE_TICK, 0, 8'd0, ST_CREATED, 9'd0);
    send_req(MODE_TICK, 0, 8'd0, ST_CREATED, 9'd0);
    send_req(MODE_SET, 0, 8'd200, ST_READY, 9'd1);
    send_req(MODE_SET, 0, 8'd1, ST_TERMINATED, 9'd0);
    send_req(MODE_SET, 0, 8'd0, ST_TERMINATED, 9'd0);
    send_req(MODE_TICK, 0, 8'd0, ST_CREATED, 9'd0);
    send_req(MODE_TICK, 0, 8'd0, ST_CREATED, 9'd0);
    send_req(MODE_SET, 1, 8'd0, ST_TERMINATED, 9'h1FF);
    send_req(MODE_TICK, 0, 8'd0, ST_CREATED, 9'd0);
    send_req(MODE_NOP, 1, 8'hFF, 3'd7, 9'h1FF);
    send_req(MODE_SET, 0, 8'd0, ST_BLOCKED, 9'd0);
    send_req(MODE_SET, 0, 8'd255, ST_BLOCKED, 9'd0);
    send_req(MODE_TICK, 0, 8'd0, ST_CREATED, 9'd0);
    send_req(MODE_SET, 0, 8'd0, ST_READY, 9'd255);
    send_req(MODE_TICK, 0, 8'd0, ST_CREATED, 9'd0);
    end_burst();
    wait_drained();

    // Random phase one: sender idles lightly, receiver stalls heavily
    send_idle_pct  = 23;
    recv_stall_pct = 73;
    write_reg(REG_SHORT, 8'd255);
    write_reg(REG_NORMAL, 8'd1);
    write_reg(REG_KERNEL, 8'd3);
    repeat (230) send_random();
    end_burst();
    wait_drained();

    // Random phase two: roles swapped
    send_idle_pct  = 73;
    recv_stall_pct = 23;
    write_reg(REG_SHORT, 8'd1);
    write_reg(REG_NORMAL, 8'd255);
    write_reg(REG_KERNEL, 8'd255);
    repeat (230) send_random();
    end_burst();
    wait_drained();

    // Random phase three: no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_SHORT, 8'd2);
    write_reg(REG_NORMAL, 8'd3);
    write_reg(REG_KERNEL, 8'd0);
    repeat (240) send_random();
    end_burst();
    wait_drained();
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

@@ round_robin_task_scheduler_core.f @@
rtl/rrts_pkg.sv
rtl/round_robin_task_scheduler_core.sv
test/tb_top.sv
